[rtl/core/skf_pkg.sv]
// Shared types and constants for the scalar Kalman filter.
// No dependencies; every other file of the filter imports this package.
package skf_pkg;

  localparam int GAIN_BITS     = 16;
  localparam int COV_WIDTH     = 32;
  localparam int NOISE_WIDTH   = 32;
  localparam int CFG_IDX_WIDTH = 2;
  // one integer quotient bit plus GAIN_BITS fraction bits
  localparam int DIV_STEPS     = GAIN_BITS + 1;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

  localparam logic [NOISE_WIDTH-1:0] MEAS_NOISE_RESET = 32'h0001_0000;
  localparam logic [COV_WIDTH-1:0]   COV_MAX          = '1;

  // load / step control for the bit-serial arithmetic units
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctrl_t;

endpackage

[rtl/core/skf_if.sv]
// Channel interfaces of the scalar Kalman filter: sample input, estimate output
// and configuration write. Depends on skf_pkg.
interface skf_in_if #(parameter int SAMPLE_WIDTH = 32) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           series_start;

  modport source (output valid, sample, series_start, input ready);
  modport sink   (input valid, sample, series_start, output ready);
endinterface

interface skf_out_if #(parameter int SAMPLE_WIDTH = 32) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

interface skf_cfg_if import skf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_WIDTH-1:0] index;
  logic [NOISE_WIDTH-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/skf_serial_div.sv]
// Restoring divider, one quotient bit per step: quot = floor(num * 2^GAIN_BITS / den).
// Requires num <= den. Depends on skf_pkg.
module skf_serial_div import skf_pkg::*; (
  input  logic                 clk,
  input  ser_ctrl_t            ctrl,
  input  logic [COV_WIDTH-1:0] num,
  input  logic [COV_WIDTH:0]   den,
  output logic [DIV_STEPS-1:0] quot
);

  logic [COV_WIDTH+1:0] rem_r, rem_nxt;
  logic [COV_WIDTH:0]   den_r, den_nxt;
  logic [DIV_STEPS-1:0] quot_r, quot_nxt;
  logic [COV_WIDTH+1:0] trial;
  logic [COV_WIDTH+1:0] kept;
  logic                 ge;

  always_comb begin
    ge       = rem_r >= {1'b0, den_r};
    trial    = rem_r - {1'b0, den_r};
    kept     = ge ? trial : rem_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (ctrl.load) begin
      rem_nxt  = {2'b00, num};
      den_nxt  = den;
      quot_nxt = '0;
    end else if (ctrl.step) begin
      // remainder stays below den, so the shifted value fits
      rem_nxt  = {kept[COV_WIDTH:0], 1'b0};
      quot_nxt = {quot_r[DIV_STEPS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign quot = quot_r;

endmodule

[rtl/core/skf_serial_mul.sv]
// Shift-and-add multiplier, one multiplier bit per step, LSB first:
// prod = floor(a * b / 2^B_WIDTH) after B_WIDTH steps. Depends on skf_pkg.
module skf_serial_mul import skf_pkg::*; #(
  parameter int A_WIDTH = 33,
  parameter int B_WIDTH = 16
) (
  input  logic               clk,
  input  ser_ctrl_t          ctrl,
  input  logic [A_WIDTH-1:0] a,
  input  logic [B_WIDTH-1:0] b,
  output logic [A_WIDTH-1:0] prod
);

  logic [A_WIDTH-1:0] a_r, a_nxt;
  logic [B_WIDTH-1:0] b_r, b_nxt;
  logic [A_WIDTH-1:0] acc_r, acc_nxt;
  logic [A_WIDTH:0]   sum;

  always_comb begin
    // dropping the low bit each step keeps the running floor exact
    sum     = {1'b0, acc_r} + (b_r[0] ? {1'b0, a_r} : '0);
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    if (ctrl.load) begin
      a_nxt   = a;
      b_nxt   = b;
      acc_nxt = '0;
    end else if (ctrl.step) begin
      b_nxt   = b_r >> 1;
      acc_nxt = sum[A_WIDTH:1];
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;

endmodule

[rtl/core/scalar_kalman_filter.sv]
// Scalar Kalman filter. One filtered estimate leaves for each sample taken. A sample
// marked series_start loads the estimate and clears the covariance; any other sample
// goes through covariance prediction, a bit-serial gain divide and two shift-add
// multiplies that run side by side, then the update. One sample is in flight at a time;
// the next is taken as soon as the result sits in the output register, even while it
// waits to be taken. Configuration writes are always taken and should only be issued
// while idle.
module scalar_kalman_filter import skf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  skf_in_if.sink    in_ch,
  skf_out_if.source out_ch,
  skf_cfg_if.sink   cfg_ch
);

  localparam int CNT_WIDTH = $clog2(DIV_STEPS);
  localparam int MAG_WIDTH = SAMPLE_WIDTH + 1;
  localparam int SUM_WIDTH = SAMPLE_WIDTH + 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_INIT, ST_DIV, ST_GAIN, ST_MUL, ST_UPD, ST_WRITE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CNT_WIDTH-1:0]           cnt_r, cnt_nxt;
  logic [NOISE_WIDTH-1:0]         pnoise_r, pnoise_nxt;
  logic [NOISE_WIDTH-1:0]         mnoise_r, mnoise_nxt;
  logic signed [SAMPLE_WIDTH-1:0] est_r, est_nxt;
  logic [COV_WIDTH-1:0]           cov_r, cov_nxt;
  logic signed [SAMPLE_WIDTH-1:0] smp_r, smp_nxt;
  logic [COV_WIDTH-1:0]           p_r, p_nxt;
  logic                           neg_r, neg_nxt;
  logic [MAG_WIDTH-1:0]           mag_r, mag_nxt;
  logic                           den_zero_r, den_zero_nxt;
  logic                           gain_zero_r, gain_zero_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_data_r, out_data_nxt;

  logic [COV_WIDTH:0]     p_sum;
  logic [COV_WIDTH:0]     den;
  logic [MAG_WIDTH-1:0]   diff;
  logic [DIV_STEPS-1:0]   quot;
  logic [GAIN_BITS-1:0]   gain;
  logic [GAIN_BITS-1:0]   gain_comp;
  logic [MAG_WIDTH-1:0]   corr;
  logic [COV_WIDTH-1:0]   cov_prod;
  logic [SUM_WIDTH-1:0]   est_ext;
  logic [SUM_WIDTH-1:0]   corr_ext;
  logic [SUM_WIDTH-1:0]   upd_sum;
  logic                   upd_ovf;
  logic [SAMPLE_WIDTH-1:0] upd_val;
  ser_ctrl_t              div_ctrl;
  ser_ctrl_t              mul_ctrl;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_data_r;

  // datapath terms
  always_comb begin
    p_sum     = {1'b0, cov_r} + {1'b0, pnoise_r};
    den       = {1'b0, p_r} + {1'b0, mnoise_r};
    diff      = {smp_r[SAMPLE_WIDTH-1], smp_r} - {est_r[SAMPLE_WIDTH-1], est_r};
    if (den_zero_r) begin
      gain = '0;
    end else if (quot[DIV_STEPS-1]) begin
      gain = '1;  // gain of one clips just below 1.0
    end else begin
      gain = quot[GAIN_BITS-1:0];
    end
    gain_comp = '0 - gain;
    est_ext   = {{2{est_r[SAMPLE_WIDTH-1]}}, est_r};
    corr_ext  = {1'b0, corr};
    upd_sum   = neg_r ? est_ext - corr_ext : est_ext + corr_ext;
    upd_ovf   = (upd_sum[SUM_WIDTH-1:SAMPLE_WIDTH-1] != {3{upd_sum[SUM_WIDTH-1]}});
    if (upd_ovf) begin
      upd_val = upd_sum[SUM_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      upd_val = upd_sum[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pnoise_nxt    = pnoise_r;
    mnoise_nxt    = mnoise_r;
    est_nxt       = est_r;
    cov_nxt       = cov_r;
    smp_nxt       = smp_r;
    p_nxt         = p_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    den_zero_nxt  = den_zero_r;
    gain_zero_nxt = gain_zero_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_ctrl      = '0;
    mul_ctrl      = '0;

    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PROCESS_NOISE:     pnoise_nxt = cfg_ch.data;
        CFG_MEASUREMENT_NOISE: mnoise_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          smp_nxt = in_ch.sample;
          if (in_ch.series_start) begin
            est_nxt   = in_ch.sample;
            cov_nxt   = '0;
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        p_nxt     = p_sum[COV_WIDTH] ? COV_MAX : p_sum[COV_WIDTH-1:0];
        neg_nxt   = diff[MAG_WIDTH-1];
        mag_nxt   = diff[MAG_WIDTH-1] ? '0 - diff : diff;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        div_ctrl.load = 1'b1;
        den_zero_nxt  = (den == '0);
        cnt_nxt       = CNT_WIDTH'(DIV_STEPS - 1);
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        div_ctrl.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_GAIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_GAIN: begin
        mul_ctrl.load = 1'b1;
        gain_zero_nxt = (gain == '0);
        cnt_nxt       = CNT_WIDTH'(GAIN_BITS - 1);
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        mul_ctrl.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_UPD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_UPD: begin
        est_nxt   = upd_val;
        // (1 - K) * P; a zero gain keeps P whole
        cov_nxt   = gain_zero_r ? p_r : cov_prod;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = est_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pnoise_r    <= '0;
      mnoise_r    <= MEAS_NOISE_RESET;
      est_r       <= '0;
      cov_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pnoise_r    <= pnoise_nxt;
      mnoise_r    <= mnoise_nxt;
      est_r       <= est_nxt;
      cov_r       <= cov_nxt;
      out_valid_r <= out_valid_nxt;
    end
    smp_r       <= smp_nxt;
    p_r         <= p_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    den_zero_r  <= den_zero_nxt;
    gain_zero_r <= gain_zero_nxt;
    out_data_r  <= out_data_nxt;
  end

  skf_serial_div u_div (
    .clk  (clk),
    .ctrl (div_ctrl),
    .num  (p_r),
    .den  (den),
    .quot (quot)
  );

  skf_serial_mul #(
    .A_WIDTH (MAG_WIDTH),
    .B_WIDTH (GAIN_BITS)
  ) u_mul_corr (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .a    (mag_r),
    .b    (gain),
    .prod (corr)
  );

  skf_serial_mul #(
    .A_WIDTH (COV_WIDTH),
    .B_WIDTH (GAIN_BITS)
  ) u_mul_cov (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .a    (p_r),
    .b    (gain_comp),
    .prod (cov_prod)
  );

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Testbench for scalar_kalman_filter: directed and random sample series are checked
// against an in-bench fixed-point predictor. Depends on skf_pkg, skf_if.sv and the RTL.
module testbench;
  import skf_pkg::*;

  localparam int SAMPLE_W    = 32;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk;
  logic rst_n;

  skf_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
  skf_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_ch ();
  skf_cfg_if                            cfg_ch ();

  scalar_kalman_filter #(.SAMPLE_WIDTH(SAMPLE_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state and its copy of the registers
  logic [NOISE_WIDTH-1:0]     q_noise;
  logic [NOISE_WIDTH-1:0]     r_noise;
  logic signed [SAMPLE_W-1:0] est_state;
  logic [COV_WIDTH-1:0]       cov_state;

  logic signed [SAMPLE_W-1:0] expected_estimates[$];

  int fail_count        = 0;
  int cycle_count       = 0;
  int send_idle_pct     = 0;
  int ready_stall_pct   = 0;
  int ready_hold_cycles = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("scalar_kalman_filter test failed");
      $finish;
    end
  end

  // one filter step: returns the estimate left after this sample
  function automatic logic signed [SAMPLE_W-1:0] kalman_update(
    logic signed [SAMPLE_W-1:0] smp, logic start);
    bit [63:0] p;
    bit [63:0] den;
    bit [63:0] gain;
    bit [63:0] mag;
    bit [63:0] corr;
    longint    diff;
    longint    nxt;
    if (start) begin
      est_state = smp;
      cov_state = '0;
    end else begin
      p = {32'd0, cov_state} + {32'd0, q_noise};
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      den  = p + {32'd0, r_noise};
      gain = '0;
      if (den != 0) begin
        gain = (p << GAIN_BITS) / den;
        if (gain > 64'd65535) gain = 64'd65535;
      end
      diff = longint'(smp) - longint'(est_state);
      mag  = (diff < 0) ? -diff : diff;
      // magnitude times gain, truncated, then the sign of the difference
      corr = (mag >> GAIN_BITS) * gain + (((mag & 64'hFFFF) * gain) >> GAIN_BITS);
      if (diff < 0) nxt = longint'(est_state) - longint'(corr);
      else          nxt = longint'(est_state) + longint'(corr);
      if (nxt > longint'(32'sh7FFF_FFFF)) nxt = longint'(32'sh7FFF_FFFF);
      if (nxt < longint'(32'sh8000_0000)) nxt = longint'(32'sh8000_0000);
      est_state = nxt[SAMPLE_W-1:0];
      cov_state = COV_WIDTH'(((64'd65536 - gain) * p) >> GAIN_BITS);
    end
    return est_state;
  endfunction

  function automatic logic [NOISE_WIDTH-1:0] pick_noise();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0001_0000;
      3:       return $urandom_range(32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= smp;
    in_ch.series_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_estimates.push_back(kalman_update(smp, start));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [NOISE_WIDTH-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_PROCESS_NOISE) q_noise = value;
    else if (idx == CFG_MEASUREMENT_NOISE) r_noise = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_estimates.size() != 0);
  endtask

  // well-formed series around a random level, with some stray items mixed in
  task automatic run_series_mix(int n_items);
    int sent;
    int seq_len;
    int k;
    logic signed [SAMPLE_W-1:0] base;
    logic signed [SAMPLE_W-1:0] smp;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_sample($urandom, 1'($urandom_range(1)));
        sent++;
      end else begin
        seq_len = $urandom_range(24, 2);
        base    = $urandom;
        send_sample(base, 1'b1);
        sent++;
        for (k = 1; k < seq_len && sent < n_items; k++) begin
          smp = base + ($signed($urandom) >>> $urandom_range(31, 6));
          send_sample(smp, 1'b0);
          sent++;
        end
      end
    end
  endtask

  // filtering from the reset state, before any series has been started
  task automatic test_no_series_start();
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0000_0001, 1'b0);
    wait_drained();
  endtask

  task automatic test_directed_corners();
    write_reg(CFG_PROCESS_NOISE, 32'h0001_0000);
    write_reg(CFG_MEASUREMENT_NOISE, 32'h0001_0000);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    wait_drained();
    // zero denominator: gain 0, estimate held
    write_reg(CFG_PROCESS_NOISE, 32'h0);
    write_reg(CFG_MEASUREMENT_NOISE, 32'h0);
    send_sample(32'sd123, 1'b1);
    send_sample(32'sd456, 1'b0);
    wait_drained();
    // r = 0 pins the gain just below one; q at max saturates the covariance
    write_reg(CFG_PROCESS_NOISE, 32'hFFFF_FFFF);
    send_sample(32'sd0, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(-32'sd5, 1'b0);
    wait_drained();
    write_reg(CFG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    wait_drained();
    write_reg(CFG_PROCESS_NOISE, 32'h0000_0001);
    send_sample(32'sh0001_0000, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_series(int idle_pct, int stall_pct);
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    repeat (6) begin
      write_reg(CFG_PROCESS_NOISE, pick_noise());
      write_reg(CFG_MEASUREMENT_NOISE, pick_noise());
      run_series_mix(100);
      wait_drained();
    end
  endtask

  // sink holds off long enough for the filter to back up onto its input
  task automatic test_output_hold_off();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    write_reg(CFG_PROCESS_NOISE, 32'h0000_4000);
    write_reg(CFG_MEASUREMENT_NOISE, 32'h0002_0000);
    ready_hold_cycles = 400;
    run_series_mix(40);
    wait_drained();
  endtask

  // sink side: ready changes on the falling edge
  always @(negedge clk) begin
    if (ready_hold_cycles > 0) begin
      ready_hold_cycles <= ready_hold_cycles - 1;
      out_ch.ready      <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_estimates.size() == 0) begin
        $error("filtered: unexpected transfer, got %0d", out_ch.filtered);
        fail_count++;
      end else begin
        want = expected_estimates.pop_front();
        if (out_ch.filtered !== want) begin
          $error("filtered: expected %0d, actual %0d", want, out_ch.filtered);
          fail_count++;
        end
      end
    end
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.series_start = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_PROCESS_NOISE;
    cfg_ch.data        = '0;
    q_noise            = '0;
    r_noise            = MEAS_NOISE_RESET;
    est_state          = '0;
    cov_state          = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct   = 15;
    ready_stall_pct = 82;
    test_no_series_start();
    test_directed_corners();
    test_random_series(15, 82);
    test_random_series(82, 15);
    test_random_series(0, 0);
    test_output_hold_off();

    in_ch.valid <= 1'b0;
    repeat (80) @(posedge clk);
    if (expected_estimates.size() != 0) begin
      $error("filtered: %0d results never arrived", expected_estimates.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("scalar_kalman_filter test passed");
    end else begin
      $display("scalar_kalman_filter test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/skf_pkg.sv
rtl/core/skf_if.sv
rtl/core/skf_serial_div.sv
rtl/core/skf_serial_mul.sv
rtl/core/scalar_kalman_filter.sv
dv/testbench.sv
